// ===== rtl/cosfr_pkg.sv =====
// Package for the CAN-over-serial frame receiver.
// Holds the payload store geometry, framing constants, a reflected CRC-8 step (poly 0x31) and shared types.
// No dependencies.
package cosfr_pkg;

  localparam int PAYLOAD_DEPTH = 64;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W         = 7;
  localparam int LEN_W         = 6;

  localparam logic [7:0] PREFIX_BYTE = 8'hA5;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_POLY_R  = 8'h8C;

  localparam logic [CNT_W-1:0] HDR_PORT_POS  = CNT_W'(0);
  localparam logic [CNT_W-1:0] HDR_FLAGS_POS = CNT_W'(5);
  localparam logic [CNT_W-1:0] HDR_CRC_POS   = CNT_W'(6);

  localparam logic REG_FD_MASK      = 1'b0;
  localparam logic REG_CLASSIC_MASK = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef struct packed {
    logic              port;
    logic [31:0]       can_id;
    logic              ext;
    logic              fd;
    logic [LEN_W-1:0]  len;
  } frame_info_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/cosfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cosfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cosfr_parser.sv =====
// Byte parser: prefix hunt, header capture, CRC-8 checking (poly 0x31, init 0xFF) and payload writes to the store.
// Depends on cosfr_pkg.
module cosfr_parser
  import cosfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        in_accept_i,
  input  logic [1:0]  fd_mask_i,
  input  logic [1:0]  classic_mask_i,
  output ram_wr_t     ram_wr_o,
  output logic        frame_start_o,
  output frame_info_t frame_info_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       crc_q, crc_d;
  logic             port_bit_q, port_bit_d;
  logic             port_bad_q, port_bad_d;
  logic [31:0]      id_q, id_d;
  logic [7:0]       flags_q, flags_d;

  logic [CNT_W-1:0] len_ext;
  logic [7:0]       crc_next;
  logic [1:0]       mask_sel;
  logic [1:0]       id_byte;
  logic             frame_ok;

  assign len_ext  = {1'b0, flags_q[LEN_W-1:0]};
  assign crc_next = crc8_step(crc_q, rx_byte_i);
  assign mask_sel = flags_q[7] ? fd_mask_i : classic_mask_i;
  assign id_byte  = cnt_q[1:0] - 2'd1;
  assign frame_ok = (rx_byte_i == crc_q) && !port_bad_q
                 && (len_ext <= CNT_W'(PAYLOAD_DEPTH)) && mask_sel[port_bit_q];

  always_comb begin
    phase_d = phase_q;
    if (in_accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == PREFIX_BYTE) begin
            phase_d = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (cnt_q == HDR_CRC_POS) begin
            phase_d = (rx_byte_i == crc_q) ? PH_PAYLOAD : PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (cnt_q == len_ext) begin
            phase_d = PH_HUNT;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    cnt_d         = cnt_q;
    crc_d         = crc_q;
    port_bit_d    = port_bit_q;
    port_bad_d    = port_bad_q;
    id_d          = id_q;
    flags_d       = flags_q;
    ram_wr_o      = '{we: 1'b0, addr: cnt_q[ADDR_W-1:0], data: rx_byte_i};
    frame_start_o = 1'b0;
    if (in_accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == PREFIX_BYTE) begin
            crc_d = crc8_step(CRC_INIT, rx_byte_i);
            cnt_d = '0;
          end
        end
        PH_HEADER: begin
          if (cnt_q == HDR_CRC_POS) begin
            cnt_d = '0;
            crc_d = (rx_byte_i == crc_q) ? crc_next : CRC_INIT;
          end else begin
            priority if (cnt_q == HDR_PORT_POS) begin
              port_bit_d = rx_byte_i[0];
              port_bad_d = |rx_byte_i[7:1];
            end else if (cnt_q == HDR_FLAGS_POS) begin
              flags_d = rx_byte_i;
            end else begin
              id_d[{id_byte, 3'b000} +: 8] = rx_byte_i;
            end
            crc_d = crc_next;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        PH_PAYLOAD: begin
          if (cnt_q == len_ext) begin
            frame_start_o = frame_ok;
            cnt_d         = '0;
            crc_d         = CRC_INIT;
          end else begin
            ram_wr_o.we = (cnt_q < CNT_W'(PAYLOAD_DEPTH));
            crc_d       = crc_next;
            cnt_d       = cnt_q + CNT_W'(1);
          end
        end
        default: begin
          cnt_d = '0;
          crc_d = CRC_INIT;
        end
      endcase
    end
  end

  assign frame_info_o = '{port: port_bit_q, can_id: id_q, ext: flags_q[6], fd: flags_q[7],
                          len: flags_q[LEN_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    port_bit_q <= port_bit_d;
    port_bad_q <= port_bad_d;
    id_q       <= id_d;
    flags_q    <= flags_d;
  end

endmodule

// ===== rtl/cosfr_drain.sv =====
// Result drain: reads a delivered frame's payload from the store and emits one beat per byte (one zero beat if empty).
// Depends on cosfr_pkg.
module cosfr_drain
  import cosfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frame_start_i,
  input  frame_info_t      frame_info_i,
  output ram_rd_t          ram_rd_o,
  input  logic [7:0]       ram_rdata_i,
  output logic             busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output frame_info_t      out_info_o,
  output logic [LEN_W-1:0] out_index_o,
  output logic [7:0]       out_data_o,
  output logic             out_last_o
);

  frame_info_t      info_q;
  logic             run_q, run_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic             pend_q, pend_d;
  logic [LEN_W-1:0] pend_idx_q;
  logic             pend_last_q;
  logic             out_valid_q, out_valid_d;
  frame_info_t      out_info_q;
  logic [LEN_W-1:0] out_idx_q;
  logic [7:0]       out_data_q;
  logic             out_last_q;

  logic issue;
  logic load;
  logic k_last;

  assign load   = pend_q && (!out_valid_q || !out_stall_i);
  assign issue  = run_q && (!pend_q || load);
  assign k_last = (info_q.len == '0) || (k_q == info_q.len - LEN_W'(1));

  assign ram_rd_o = '{re: issue, addr: k_q[ADDR_W-1:0]};
  assign busy_o   = run_q || pend_q;

  always_comb begin
    run_d       = run_q;
    k_d         = k_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (frame_start_i) begin
      run_d = 1'b1;
      k_d   = '0;
    end else if (issue) begin
      run_d = !k_last;
      k_d   = k_q + LEN_W'(1);
    end
    if (issue) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_start_i) begin
      info_q <= frame_info_i;
    end
    if (issue) begin
      pend_idx_q  <= k_q;
      pend_last_q <= k_last;
    end
    if (load) begin
      out_info_q <= info_q;
      out_idx_q  <= pend_idx_q;
      out_data_q <= (info_q.len == '0) ? 8'h00 : ram_rdata_i;
      out_last_q <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_info_o  = out_info_q;
  assign out_index_o = out_idx_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/can_over_serial_frame_receiver.sv =====
// Top level of the CAN-over-serial frame receiver: register port, parser, payload store, drain.
// Depends on cosfr_pkg, cosfr_parser, cosfr_ram and cosfr_drain.
//
//   channel | dir | handshake              | beat contents
//   --------+-----+------------------------+---------------------------------------------
//   input   | in  | in_valid_i/in_stall_o  | rx_byte_i
//   output  | out | out_valid_o/out_stall_i| can_port_o .. last_o, one payload byte
//   config  | in  | APB psel/penable/pready| fd_port_mask at 0x0, classic_port_mask at 0x4
//
// The input takes one serial byte per cycle while it is not stalled. The frame CRC byte of a delivered
// frame starts a drain of max(length, 1) beats, one per cycle from the store's read port while the output
// does not stall; the input is stalled until the last read has been issued and its data taken into the
// output stage.
// Reset clears the control state only; the store needs no clearing pass.
// A stall on the output holds the drain, and so the input as well while a frame is draining.
module can_over_serial_frame_receiver
  import cosfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             can_port_o,
  output logic [31:0]      can_id_o,
  output logic             extended_o,
  output logic             fd_frame_o,
  output logic [LEN_W-1:0] payload_length_o,
  output logic [LEN_W-1:0] byte_index_o,
  output logic [7:0]       data_byte_o,
  output logic             last_o
);

  logic [1:0]  fd_mask_q, fd_mask_d;
  logic [1:0]  classic_mask_q, classic_mask_d;
  logic        cfg_write;
  logic        in_accept;
  logic        drain_busy;
  logic        frame_start;
  frame_info_t frame_info;
  frame_info_t out_info;
  ram_wr_t     ram_wr;
  ram_rd_t     ram_rd;
  logic [7:0]  ram_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    fd_mask_d      = fd_mask_q;
    classic_mask_d = classic_mask_q;
    if (cfg_write) begin
      unique case (paddr[2])
        REG_FD_MASK:      fd_mask_d      = pwdata[1:0];
        REG_CLASSIC_MASK: classic_mask_d = pwdata[1:0];
        default:          fd_mask_d      = fd_mask_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FD_MASK:      prdata = {30'd0, fd_mask_q};
      REG_CLASSIC_MASK: prdata = {30'd0, classic_mask_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_mask_q      <= '0;
      classic_mask_q <= '0;
    end else begin
      fd_mask_q      <= fd_mask_d;
      classic_mask_q <= classic_mask_d;
    end
  end

  assign in_stall_o = drain_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  cosfr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .in_accept_i    (in_accept),
    .fd_mask_i      (fd_mask_q),
    .classic_mask_i (classic_mask_q),
    .ram_wr_o       (ram_wr),
    .frame_start_o  (frame_start),
    .frame_info_o   (frame_info)
  );

  cosfr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.re),
    .raddr_i (ram_rd.addr),
    .rdata_o (ram_rdata)
  );

  cosfr_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_start_i (frame_start),
    .frame_info_i  (frame_info),
    .ram_rd_o      (ram_rd),
    .ram_rdata_i   (ram_rdata),
    .busy_o        (drain_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_info_o    (out_info),
    .out_index_o   (byte_index_o),
    .out_data_o    (data_byte_o),
    .out_last_o    (last_o)
  );

  assign can_port_o       = out_info.port;
  assign can_id_o         = out_info.can_id;
  assign extended_o       = out_info.ext;
  assign fd_frame_o       = out_info.fd;
  assign payload_length_o = out_info.len;

  a_no_write_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr.we |-> !drain_busy)
    else $error("payload store written while a frame is draining");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_start |=> drain_busy)
    else $error("drain did not start after a delivered frame");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_length_o != '0) |-> (byte_index_o < payload_length_o))
    else $error("byte index beyond payload length");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && payload_length_o != '0)
      |-> (byte_index_o == payload_length_o - LEN_W'(1)))
    else $error("last beat not on the final payload byte");

endmodule

// ===== tb/tb_can_over_serial_frame_receiver.sv =====
// Self-checking testbench for the CAN-over-serial frame receiver: serial frames go in, and every
// delivered payload beat is checked against a predictor that parses the same byte stream.
// Depends on cosfr_pkg and can_over_serial_frame_receiver.
`timescale 1ns / 1ps

module tb_can_over_serial_frame_receiver;
  import cosfr_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_SETTLE     = 8;
  localparam int FINAL_SETTLE     = 20;

  typedef enum {FRAME_GOOD, FRAME_BAD_HDR_CRC, FRAME_BAD_CRC} frame_fault_e;

  typedef struct packed {
    logic             port;
    logic [31:0]      id;
    logic             ext;
    logic             fd;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
    logic             last;
  } can_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       rx_byte_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             can_port_o;
  logic [31:0]      can_id_o;
  logic             extended_o;
  logic             fd_frame_o;
  logic [LEN_W-1:0] payload_length_o;
  logic [LEN_W-1:0] byte_index_o;
  logic [7:0]       data_byte_o;
  logic             last_o;

  can_beat_t expected_beats[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        frame_bytes = 0;
  bit        gaps_on = 1'b1;
  bit        long_hold_req = 1'b0;
  bit        long_hold_done = 1'b0;

  logic [1:0]       fd_enable = 2'b00;
  logic [1:0]       classic_enable = 2'b00;
  phase_e           rx_phase = PH_HUNT;
  logic [CNT_W-1:0] rx_count = '0;
  logic [7:0]       rx_crc = CRC_INIT;
  logic [7:0]       hdr_port = 8'h00;
  logic [31:0]      hdr_id = 32'h0;
  logic [7:0]       hdr_flags = 8'h00;
  logic             hdr_crc_ok = 1'b0;
  logic [7:0]       payload_mem [PAYLOAD_DEPTH];

  can_over_serial_frame_receiver i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .can_port_o       (can_port_o),
    .can_id_o         (can_id_o),
    .extended_o       (extended_o),
    .fd_frame_o       (fd_frame_o),
    .payload_length_o (payload_length_o),
    .byte_index_o     (byte_index_o),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] crc8_maxim(input logic [7:0] crc, input logic [7:0] value);
    logic [7:0] acc;
    logic       lsb;
    acc = crc ^ value;
    repeat (8) begin
      lsb = acc[0];
      acc = acc >> 1;
      if (lsb) begin
        acc = acc ^ CRC_POLY_R;
      end
    end
    return acc;
  endfunction

  function automatic void restart_hunt();
    rx_phase   = PH_HUNT;
    rx_count   = '0;
    rx_crc     = CRC_INIT;
    hdr_crc_ok = 1'b0;
  endfunction

  function automatic void predict_rx_byte(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    logic             deliver;
    int               n;
    can_beat_t        beat;
    case (rx_phase)
      PH_HUNT: begin
        if (b == PREFIX_BYTE) begin
          rx_crc   = crc8_maxim(CRC_INIT, b);
          rx_count = '0;
          rx_phase = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (rx_count == HDR_CRC_POS) begin
          if (b != rx_crc) begin
            restart_hunt();
          end else begin
            hdr_crc_ok = 1'b1;
            rx_crc     = crc8_maxim(rx_crc, b);
            rx_count   = '0;
            rx_phase   = PH_PAYLOAD;
          end
        end else begin
          if (rx_count == HDR_PORT_POS) begin
            hdr_port = b;
          end else if (rx_count < HDR_FLAGS_POS) begin
            hdr_id[8*(rx_count-1) +: 8] = b;
          end else begin
            hdr_flags = b;
          end
          rx_crc   = crc8_maxim(rx_crc, b);
          rx_count = rx_count + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        len = hdr_flags[5:0];
        if (rx_count < len) begin
          payload_mem[rx_count[ADDR_W-1:0]] = b;
          rx_crc   = crc8_maxim(rx_crc, b);
          rx_count = rx_count + 1'b1;
        end else begin
          deliver = (b == rx_crc) && hdr_crc_ok && (hdr_port <= 8'd1);
          if (deliver) begin
            deliver = hdr_flags[7] ? fd_enable[hdr_port[0]] : classic_enable[hdr_port[0]];
          end
          restart_hunt();
          if (deliver) begin
            n = (len == 0) ? 1 : int'(len);
            for (int k = 0; k < n; k++) begin
              beat.port = hdr_port[0];
              beat.id   = hdr_id;
              beat.ext  = hdr_flags[6];
              beat.fd   = hdr_flags[7];
              beat.len  = len;
              beat.idx  = LEN_W'(k);
              beat.data = (len == 0) ? 8'h00 : payload_mem[ADDR_W'(k)];
              beat.last = (k == n - 1);
              expected_beats.push_back(beat);
            end
          end
        end
      end
      default: begin
        restart_hunt();
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_beats
    can_beat_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual id 0x%0h index %0d", $time,
                 can_id_o, byte_index_o);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("can_port", want.port, can_port_o);
        compare_field("can_id", want.id, can_id_o);
        compare_field("extended", want.ext, extended_o);
        compare_field("fd_frame", want.fd, fd_frame_o);
        compare_field("payload_length", want.len, payload_length_o);
        compare_field("byte_index", want.idx, byte_index_o);
        compare_field("data_byte", want.data, data_byte_o);
        compare_field("last", want.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls in four patterns taken in turn, with a long hold on request.
  initial begin : receiver_stall
    int stall_tick;
    stall_tick = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold_done = 1'b1;
      end
      stall_tick++;
      case ((stall_tick / 48) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (stall_tick % 3 == 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_rx_byte(value);
  endtask

  task automatic send_frame(input logic [7:0] port, input logic [31:0] id,
                            input logic [7:0] flags, input frame_fault_e fault);
    logic [7:0] crc;
    logic [7:0] value;
    crc = crc8_maxim(CRC_INIT, PREFIX_BYTE);
    send_byte(PREFIX_BYTE);
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: value = port;
        5: value = flags;
        default: value = id[8*(i-1) +: 8];
      endcase
      send_byte(value);
      crc = crc8_maxim(crc, value);
    end
    value = crc;
    if (fault == FRAME_BAD_HDR_CRC) begin
      value = value ^ 8'($urandom_range(1, 255));
    end
    send_byte(value);
    frame_bytes += 8;
    if (fault == FRAME_BAD_HDR_CRC) begin
      return;
    end
    crc = crc8_maxim(crc, value);
    for (int i = 0; i < flags[5:0]; i++) begin
      value = 8'($urandom);
      send_byte(value);
      crc = crc8_maxim(crc, value);
    end
    if (fault == FRAME_BAD_CRC) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    send_byte(crc);
    frame_bytes += int'(flags[5:0]) + 1;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_SETTLE) @(negedge clk_i);
  endtask

  task automatic write_mask_reg(input logic reg_sel, input logic [1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {30'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (reg_sel == REG_FD_MASK) begin
      fd_enable = value;
    end else begin
      classic_enable = value;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    compare_field("prdata", 32'(value), 32'(prdata[1:0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_access();
    write_mask_reg(REG_FD_MASK, 2'b11);
    write_mask_reg(REG_CLASSIC_MASK, 2'b00);
    write_mask_reg(REG_FD_MASK, 2'b00);
    write_mask_reg(REG_CLASSIC_MASK, 2'b11);
    write_mask_reg(REG_FD_MASK, 2'b11);
  endtask

  task automatic test_hunting_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_frame(8'd1, 32'hFFFF_FFFF, 8'hC0, FRAME_GOOD);
  endtask

  task automatic test_extreme_fields();
    send_frame(8'd0, 32'h0000_0000, 8'h00, FRAME_GOOD);
    send_frame(8'd1, 32'hFFFF_FFFF, 8'hFF, FRAME_GOOD);
    send_frame(8'd0, 32'h8000_0001, 8'h41, FRAME_GOOD);
  endtask

  task automatic test_crc_errors();
    send_frame(8'd0, 32'h1234_5678, 8'h01, FRAME_BAD_HDR_CRC);
    send_frame(8'd1, 32'h0BAD_C0DE, 8'h02, FRAME_BAD_CRC);
    send_frame(8'd0, 32'h0000_00A5, 8'h00, FRAME_GOOD);
  endtask

  task automatic test_bad_port();
    send_frame(8'd2, 32'h0000_0100, 8'h01, FRAME_GOOD);
    send_frame(8'hFF, 32'h0000_0200, 8'h80, FRAME_GOOD);
    send_frame(8'd1, 32'h0000_0300, 8'h00, FRAME_GOOD);
  endtask

  task automatic test_port_enables();
    wait_idle();
    write_mask_reg(REG_FD_MASK, 2'b01);
    write_mask_reg(REG_CLASSIC_MASK, 2'b10);
    send_frame(8'd0, 32'h0000_0011, 8'h80, FRAME_GOOD);
    send_frame(8'd1, 32'h0000_0012, 8'h80, FRAME_GOOD);
    send_frame(8'd0, 32'h0000_0013, 8'h00, FRAME_GOOD);
    send_frame(8'd1, 32'h0000_0014, 8'h00, FRAME_GOOD);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    write_mask_reg(REG_FD_MASK, 2'b11);
    write_mask_reg(REG_CLASSIC_MASK, 2'b11);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 3; i++) begin
      send_frame(8'(i % 2), 32'($urandom), {2'b00, 6'($urandom_range(8, 12))}, FRAME_GOOD);
    end
    gaps_on = 1'b1;
  endtask

  task automatic random_frame();
    int           pick;
    int           len;
    logic [7:0]   port;
    frame_fault_e fault;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      return;
    end
    if (pick < 10) begin
      send_byte(PREFIX_BYTE);
    end
    port = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    len = (pick < 85) ? $urandom_range(0, 8) :
          (pick < 95) ? $urandom_range(9, 31) : $urandom_range(32, 63);
    pick = $urandom_range(0, 99);
    fault = (pick < 6) ? FRAME_BAD_HDR_CRC : (pick < 12) ? FRAME_BAD_CRC : FRAME_GOOD;
    send_frame(port, 32'($urandom),
               {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 6'(len)}, fault);
  endtask

  task automatic test_random_traffic();
    logic [1:0] fd_sel;
    logic [1:0] classic_sel;
    int         budget;
    for (int step = 0; step < 6; step++) begin
      case (step)
        0: begin
          fd_sel = 2'b11;
          classic_sel = 2'b11;
        end
        1: begin
          fd_sel = 2'b00;
          classic_sel = 2'b00;
        end
        2: begin
          fd_sel = 2'b01;
          classic_sel = 2'b10;
        end
        3: begin
          fd_sel = 2'b10;
          classic_sel = 2'b01;
        end
        default: begin
          fd_sel = 2'($urandom);
          classic_sel = 2'($urandom);
        end
      endcase
      wait_idle();
      write_mask_reg(REG_FD_MASK, fd_sel);
      write_mask_reg(REG_CLASSIC_MASK, classic_sel);
      gaps_on = (step != 2);
      budget = (step == 1) ? 8 : 12;
      frame_bytes = 0;
      while (frame_bytes < budget) begin
        random_frame();
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_hunting_noise();
    test_extreme_fields();
    test_crc_errors();
    test_bad_port();
    test_port_enables();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (FINAL_SETTLE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
